### rtl/core/sse_pkg.sv
// ============================================================================
// sse_pkg: shared types and codes of the sorted set engine
// Operation and status codes and the fixed field widths of the stream ports.
// ============================================================================
package sse_pkg;

    // operation codes carried on the input tuser
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_ERASE  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // status codes returned with every result
    typedef enum logic [1:0] {
        STS_DONE    = 2'd0,
        STS_PRESENT = 2'd1,
        STS_FULL    = 2'd2,
        STS_ABSENT  = 2'd3
    } status_t;

    localparam int unsigned ITEM_WIDTH   = 32;
    localparam int unsigned POS_WIDTH    = 10;
    localparam int unsigned SIZE_WIDTH   = 11;
    localparam int unsigned IN_TDATA_W   = 32;
    localparam int unsigned OUT_TDATA_W  = 32;
    localparam int unsigned RESULT_BITS  = 2 + 1 + POS_WIDTH + SIZE_WIDTH + 1;

endpackage

### rtl/core/sorted_set_engine_unit.sv
// ============================================================================
// sorted_set_engine_unit: sorted set of distinct values in one memory
// Insert, erase, lookup and clear on an ascending array of stored values.
// ============================================================================
//
// Usage
//   Each request on the slave stream carries an operation on s_axis_tuser and
//   a value on s_axis_tdata. Exactly one result leaves on the master stream
//   per request: status, membership flag, sorted position, size and empty.
//   The unit handles one request at a time; s_axis_tready is high only while
//   the sequencer is idle.
//   A clear, or any request on an empty set, goes straight to the result;
//   a lookup scans the set from entry zero; an insert or erase scans, then
//   shifts the entries above the slot where a gap must open or close.
//   The linear search and the shift both go through the single memory read
//   port, one entry per cycle, reading one index ahead of the write so the
//   shift closes or opens the gap at one entry per cycle.
//   The result sits in an output register; the next request is taken while
//   that result still waits, and the unit stalls only when a newer result is
//   ready while the old one has not been taken.
//   Reset empties the set at once (occupancy to zero); the memory is not
//   swept, as only entries below the occupancy are ever read.
//
module sorted_set_engine_unit #(
    parameter int unsigned MAX_ENTRIES = 1024,
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] item_value
    input  logic [sse_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [1:0] action
    input  logic [1:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] status, [2] found, [12:3] position, [23:13] set_size,
    // [24] is_empty, [31:25] zero
    output logic [sse_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

    localparam int unsigned AW = $clog2(MAX_ENTRIES);
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_ENTRIES);

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SEARCH   = 6'b000010,
        ST_SHIFT_UP = 6'b000100,
        ST_SHIFT_DN = 6'b001000,
        ST_PLACE    = 6'b010000,
        ST_RESP     = 6'b100000
    } state_t;

    // storage: entries 0 .. occupancy-1 hold the set in ascending order
    logic [VALUE_WIDTH-1:0] mem [MAX_ENTRIES];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          occ_reg, occ_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [CW-1:0]          k_reg, k_next;
    sse_pkg::op_t           op_reg, op_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;

    // result waiting for the output register
    sse_pkg::status_t       res_status_reg, res_status_next;
    logic                   res_found_reg, res_found_next;
    logic [CW-1:0]          res_pos_reg, res_pos_next;

    // output register
    logic                   m_valid_reg, m_valid_next;
    logic [sse_pkg::RESULT_BITS-1:0] m_data_reg, m_data_next;

    // memory port controls
    logic                   we;
    logic [AW-1:0]          waddr;
    logic [VALUE_WIDTH-1:0] wdata;
    logic [AW-1:0]          raddr;

    // decision point, reached from idle or from the search
    logic                   decide;
    logic                   dec_present;
    logic [CW-1:0]          dec_idx;
    logic [CW-1:0]          dec_inc;
    sse_pkg::op_t           dec_op;
    logic [VALUE_WIDTH-1:0] dec_val;

    logic                   in_accept;
    sse_pkg::op_t           in_op;
    logic [VALUE_WIDTH-1:0] in_val;

    logic [CW-1:0]          idx_inc;
    logic [CW-1:0]          k_inc;
    logic [CW-1:0]          k_inc2;
    logic [CW-1:0]          k_dec;
    logic [CW-1:0]          k_dec2;
    logic [CW-1:0]          occ_inc;
    logic [CW-1:0]          occ_dec;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_op         = sse_pkg::op_t'(s_axis_tuser);
    // keep the low VALUE_WIDTH bits of the request value, zero-extend above
    assign in_val        = VALUE_WIDTH'({{VALUE_WIDTH{1'b0}}, s_axis_tdata});

    assign idx_inc = CW'(idx_reg + 1'b1);
    assign k_inc   = CW'(k_reg + 1'b1);
    assign k_inc2  = CW'(k_reg + 2'd2);
    assign k_dec   = CW'(k_reg - 1'b1);
    assign k_dec2  = CW'(k_reg - 2'd2);
    assign occ_inc = CW'(occ_reg + 1'b1);
    assign occ_dec = CW'(occ_reg - 1'b1);
    assign dec_inc = CW'(dec_idx + 1'b1);

    always_comb
    begin
        state_next      = state_reg;
        occ_next        = occ_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_pos_next    = res_pos_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_data_next     = m_data_reg;
        we              = 1'b0;
        waddr           = '0;
        wdata           = '0;
        raddr           = '0;
        decide          = 1'b0;
        dec_present     = 1'b0;
        dec_idx         = '0;
        dec_op          = op_reg;
        dec_val         = val_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next  = in_op;
                    val_next = in_val;
                    dec_op   = in_op;
                    dec_val  = in_val;
                    if (in_op == sse_pkg::OP_CLEAR || occ_reg == '0)
                    begin
                        decide = 1'b1;
                    end
                    else
                    begin
                        // start the scan at entry zero
                        idx_next   = '0;
                        raddr      = '0;
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                // rd_data_reg holds entry idx_reg; stop at the first one not below
                if (rd_data_reg >= val_reg)
                begin
                    decide      = 1'b1;
                    dec_present = (rd_data_reg == val_reg);
                    dec_idx     = idx_reg;
                end
                else if (idx_inc == occ_reg)
                begin
                    decide  = 1'b1;
                    dec_idx = idx_inc;
                end
                else
                begin
                    idx_next = idx_inc;
                    raddr    = idx_inc[AW-1:0];
                end
            end
            ST_SHIFT_UP:
            begin
                // move entry k-1 up into k, reading k-2 for the next cycle
                we    = 1'b1;
                waddr = k_reg[AW-1:0];
                wdata = rd_data_reg;
                if (k_dec == idx_reg)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    k_next = k_dec;
                    raddr  = k_dec2[AW-1:0];
                end
            end
            ST_SHIFT_DN:
            begin
                // move entry k+1 down into k, reading k+2 for the next cycle
                we    = 1'b1;
                waddr = k_reg[AW-1:0];
                wdata = rd_data_reg;
                if (k_inc2 == occ_reg)
                begin
                    occ_next   = occ_dec;
                    state_next = ST_RESP;
                end
                else
                begin
                    k_next = k_inc;
                    raddr  = k_inc2[AW-1:0];
                end
            end
            ST_PLACE:
            begin
                we         = 1'b1;
                waddr      = idx_reg[AW-1:0];
                wdata      = val_reg;
                occ_next   = occ_inc;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // hand over once the output register is free or being freed
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {
                        (occ_reg == '0),
                        sse_pkg::SIZE_WIDTH'({{sse_pkg::SIZE_WIDTH{1'b0}}, occ_reg}),
                        sse_pkg::POS_WIDTH'({{sse_pkg::POS_WIDTH{1'b0}}, res_pos_reg}),
                        res_found_reg,
                        res_status_reg
                    };
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (decide)
        begin
            res_status_next = sse_pkg::STS_DONE;
            res_found_next  = 1'b0;
            res_pos_next    = '0;
            state_next      = ST_RESP;
            case (dec_op)
                sse_pkg::OP_INSERT:
                begin
                    if (dec_present)
                    begin
                        res_status_next = sse_pkg::STS_PRESENT;
                        res_found_next  = 1'b1;
                        res_pos_next    = dec_idx;
                    end
                    else if (occ_reg == FULL_COUNT)
                    begin
                        res_status_next = sse_pkg::STS_FULL;
                    end
                    else if (dec_idx == occ_reg)
                    begin
                        // append at the end, no gap to open
                        we       = 1'b1;
                        waddr    = dec_idx[AW-1:0];
                        wdata    = dec_val;
                        occ_next = occ_inc;
                    end
                    else
                    begin
                        idx_next   = dec_idx;
                        k_next     = occ_reg;
                        raddr      = occ_dec[AW-1:0];
                        state_next = ST_SHIFT_UP;
                    end
                end
                sse_pkg::OP_ERASE:
                begin
                    if (dec_present)
                    begin
                        res_found_next = 1'b1;
                        res_pos_next   = dec_idx;
                        if (dec_inc == occ_reg)
                        begin
                            // last entry: drop it by shrinking the count
                            occ_next = occ_dec;
                        end
                        else
                        begin
                            k_next     = dec_idx;
                            raddr      = dec_inc[AW-1:0];
                            state_next = ST_SHIFT_DN;
                        end
                    end
                    else
                    begin
                        res_status_next = sse_pkg::STS_ABSENT;
                    end
                end
                sse_pkg::OP_LOOKUP:
                begin
                    if (dec_present)
                    begin
                        res_found_next = 1'b1;
                        res_pos_next   = dec_idx;
                    end
                    else
                    begin
                        res_status_next = sse_pkg::STS_ABSENT;
                    end
                end
                default:
                begin
                    occ_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        k_reg          <= k_next;
        op_reg         <= op_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_pos_reg    <= res_pos_next;
        m_data_reg     <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = sse_pkg::OUT_TDATA_W'({{sse_pkg::OUT_TDATA_W{1'b0}}, m_data_reg});

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= FULL_COUNT)
        else $error("occupancy above capacity");

    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg != $past(occ_reg)) |->
            (occ_reg == '0 || occ_reg == CW'($past(occ_reg) + 1'b1) ||
             occ_reg == CW'($past(occ_reg) - 1'b1)))
        else $error("occupancy moved by more than one entry");

    a_shift_up_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT_UP) |-> (occ_reg < FULL_COUNT && k_reg > idx_reg))
        else $error("insert shift on a full store or past its slot");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == ST_RESP))
        else $error("result raised outside the response step");

endmodule
